FILE: rtl/mrle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrle_pkg: shared types and constants of the marker run-length decoder
// Register map, reset values, decode phases and the structs passed between
// the register file, the decode core and the top level.
// ----------------------------------------------------------------------------
package mrle_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int ADDR_W     = 16;
   localparam int NEXT_W     = 17;
   localparam int RSP_DATA_W = 40;

   localparam logic [7:0]        MARKER       = 8'hED;
   localparam logic [ADDR_W-1:0] RESET_BASE   = 16'h4000;
   localparam logic [ADDR_W-1:0] RESET_LENGTH = 16'hC000;
   localparam logic              RESET_COMP   = 1'b1;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_BASE       = 2'd0;
   localparam logic [1:0] REG_LENGTH     = 2'd1;
   localparam logic [1:0] REG_COMPRESSED = 2'd2;

   typedef enum logic [1:0] {
      PH_NORMAL = 2'd0,
      PH_COUNT  = 2'd1,
      PH_VALUE  = 2'd2
   } phase_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic              truncated;
      logic              block_done;
      logic [7:0]        run_length;
      logic [7:0]        write_value;
      logic [ADDR_W-1:0] write_address;
   } result_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base_address;
      logic [ADDR_W-1:0] block_length;
      logic              compressed;
      logic              restart;
   } cfg_type;

endpackage
`default_nettype wire

FILE: rtl/mrle_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrle_csr: configuration registers
// Holds base address, block length and mode; pulses restart after any write
// to a register in the map.
// ----------------------------------------------------------------------------
module mrle_csr
   import mrle_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] length_ff, length_in;
   logic              comp_ff, comp_in;
   logic              restart_ff, restart_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      base_in    = base_ff;
      length_in  = length_ff;
      comp_in    = comp_ff;
      restart_in = 1'b0;
      if (wr_en) begin
         case (reg_idx)
            REG_BASE: begin
               base_in    = csr_pwdata[ADDR_W-1:0];
               restart_in = 1'b1;
            end
            REG_LENGTH: begin
               length_in  = csr_pwdata[ADDR_W-1:0];
               restart_in = 1'b1;
            end
            REG_COMPRESSED: begin
               comp_in    = csr_pwdata[0];
               restart_in = 1'b1;
            end
            default: begin
               restart_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= RESET_BASE;
         length_ff  <= RESET_LENGTH;
         comp_ff    <= RESET_COMP;
         restart_ff <= 1'b0;
      end else begin
         base_ff    <= base_in;
         length_ff  <= length_in;
         comp_ff    <= comp_in;
         restart_ff <= restart_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BASE:       csr_prdata = {{(CSR_DATA_W-ADDR_W){1'b0}}, base_ff};
         REG_LENGTH:     csr_prdata = {{(CSR_DATA_W-ADDR_W){1'b0}}, length_ff};
         REG_COMPRESSED: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, comp_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.base_address = base_ff;
   assign cfg.block_length = length_ff;
   assign cfg.compressed   = comp_ff;
   assign cfg.restart      = restart_ff;

endmodule
`default_nettype wire

FILE: rtl/mrle_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrle_core: decode state and single-step logic
// Holds the address, marker and phase state; works out the result of one
// item and advances the state when the item is taken.
// ----------------------------------------------------------------------------
module mrle_core
   import mrle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       step,
   input  wire item_type   item,
   output result_type      result
);

   logic [NEXT_W-1:0] next_ff, next_in;
   logic              marker_ff, marker_in;
   phase_type         phase_ff, phase_in;
   logic [7:0]        count_ff, count_in;
   logic              fin_ff, fin_in;
   logic              trunc_ff, trunc_in;

   logic [NEXT_W-1:0] end_addr;
   logic [NEXT_W-1:0] lit_next;
   logic [NEXT_W-1:0] run_start;
   logic [NEXT_W-1:0] run_next;

   assign end_addr  = {1'b0, cfg.base_address} + {1'b0, cfg.block_length};
   assign lit_next  = next_ff + NEXT_W'(1);
   assign run_start = next_ff - NEXT_W'(1);
   assign run_next  = run_start + {{(NEXT_W-8){1'b0}}, count_ff};

   always_comb begin
      next_in   = next_ff;
      marker_in = marker_ff;
      phase_in  = phase_ff;
      count_in  = count_ff;
      fin_in    = fin_ff;
      trunc_in  = trunc_ff;
      result    = '0;
      if (item.req_type) begin
         if (!fin_ff) begin
            trunc_in = 1'b1;
         end
      end else if (!fin_ff && !trunc_ff) begin
         case (phase_ff)
            PH_COUNT: begin
               count_in = item.data_byte;
               phase_in = PH_VALUE;
            end
            PH_VALUE: begin
               // run goes back over the literal marker already written
               result.write_address = run_start[ADDR_W-1:0];
               result.write_value   = item.data_byte;
               result.run_length    = count_ff;
               next_in   = run_next;
               marker_in = 1'b0;
               phase_in  = PH_NORMAL;
               fin_in    = fin_ff | (run_next >= end_addr);
            end
            PH_NORMAL: begin
               if (cfg.compressed && item.data_byte == MARKER && marker_ff) begin
                  phase_in = PH_COUNT;
               end else begin
                  result.write_address = next_ff[ADDR_W-1:0];
                  result.write_value   = item.data_byte;
                  result.run_length    = 8'd1;
                  next_in   = lit_next;
                  marker_in = (item.data_byte == MARKER);
                  fin_in    = fin_ff | (lit_next >= end_addr);
               end
            end
            default: begin
               phase_in = PH_NORMAL;
            end
         endcase
      end
      result.block_done = fin_in;
      result.truncated  = trunc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff   <= {1'b0, RESET_BASE};
         marker_ff <= 1'b0;
         phase_ff  <= PH_NORMAL;
         count_ff  <= '0;
         fin_ff    <= (RESET_LENGTH == '0);
         trunc_ff  <= 1'b0;
      end else if (cfg.restart) begin
         next_ff   <= {1'b0, cfg.base_address};
         marker_ff <= 1'b0;
         phase_ff  <= PH_NORMAL;
         count_ff  <= '0;
         fin_ff    <= (cfg.block_length == '0);
         trunc_ff  <= 1'b0;
      end else if (step) begin
         next_ff   <= next_in;
         marker_ff <= marker_in;
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         fin_ff    <= fin_in;
         trunc_ff  <= trunc_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/marker_rle_block_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// marker_rle_block_decoder: marker run-length block decoder, top level
// Turns the byte stream of one memory block into write commands.
// ----------------------------------------------------------------------------
// One transfer in gives exactly one transfer out, at a sustained rate of one
// item per clock while rsp_tready stays high. An item passes an input
// register, the decode step (a 17-bit add and compare against the block end)
// and a result register: it is held in the input register, then in the
// result register, from which it transfers when the output is not stalled.
// The two registers keep accepting while a finished result
// waits; req_tready drops only when both hold an item and rsp_tready is low.
// A write to any mapped register restarts the block; the restart lands in
// the decode state in the cycle after the write, with no clearing pass.
// ----------------------------------------------------------------------------
module marker_rle_block_decoder
   import mrle_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tuser,   // [0] req_type
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] write_address, [23:16] write_value, [31:24] run_length,
   // [32] block_done, [33] truncated, [39:34] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // configuration
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   logic       advance;

   mrle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // move the held item into the result register when that slot is free
   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | ~rsp_valid_ff | rsp_tready;

   mrle_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_comb begin
      // input register: fill on a transfer, empty when its item moves on
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      // result register: load on advance, drop once the result is taken
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: hold unless loaded
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.req_type  <= req_tuser;
         in_item_ff.data_byte <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-$bits(result_type)){1'b0}}, rsp_data_ff};

endmodule
`default_nettype wire

FILE: rtl/mrle_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrle_checker: port-level checks of the marker run-length decoder
// Watches the stream and configuration ports; bound to the top level.
// ----------------------------------------------------------------------------
module mrle_checker
   import mrle_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  csr_pready
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // both registers empty straight after reset
   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_tready && !rsp_tvalid)
      else $error("not ready after reset");

   // a free-running output never throttles the input
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled with output ready");

   // once truncated, nothing more is written
   a_trunc_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[31:16] == 16'h0000)
      else $error("write reported on a truncated block");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind marker_rle_block_decoder mrle_checker u_mrle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
`default_nettype wire

FILE: bench/mrle_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrle_tb_pkg: write-command tracker for the marker run-length decoder bench
// Keeps its own copy of the decoder registers and decode state, works out
// the write command that each accepted stream transfer should produce and
// checks the commands that come back against them in order.
// ----------------------------------------------------------------------------
package mrle_tb_pkg;
   import mrle_pkg::*;

   localparam logic       ITEM_DATA  = 1'b0;
   localparam logic       ITEM_END   = 1'b1;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   class write_cmd_tracker;
      logic [ADDR_W-1:0] base_address;
      logic [ADDR_W-1:0] block_length;
      logic              compressed;
      logic [NEXT_W-1:0] next_address;
      logic              after_marker;
      phase_type         phase;
      logic [7:0]        held_count;
      logic              done;
      logic              truncated;
      result_type        pending_writes[$];
      int unsigned       errors;

      function new();
         base_address = RESET_BASE;
         block_length = RESET_LENGTH;
         compressed   = RESET_COMP;
         errors       = 0;
         restart();
      endfunction

      function void update_done();
         if (next_address >= {1'b0, base_address} + {1'b0, block_length}) begin
            done = 1'b1;
         end
      endfunction

      function void restart();
         next_address = {1'b0, base_address};
         after_marker = 1'b0;
         phase        = PH_NORMAL;
         held_count   = '0;
         done         = 1'b0;
         truncated    = 1'b0;
         update_done();
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_BASE:       base_address = value[ADDR_W-1:0];
            REG_LENGTH:     block_length = value[ADDR_W-1:0];
            REG_COMPRESSED: compressed   = value[0];
            default:        return;
         endcase
         restart();
      endfunction

      function logic [31:0] read_reg(logic [1:0] index);
         case (index)
            REG_BASE:       return {16'h0, base_address};
            REG_LENGTH:     return {16'h0, block_length};
            REG_COMPRESSED: return {31'h0, compressed};
            default:        return '0;
         endcase
      endfunction

      // returns 1 when the transfer changed the decode state
      function bit note_input(logic item_kind, logic [7:0] data_byte);
         result_type        want;
         logic [NEXT_W-1:0] start;
         bit                acted;
         want  = '0;
         acted = 1'b0;
         if (item_kind == ITEM_END) begin
            if (!done) begin
               truncated = 1'b1;
               acted     = 1'b1;
            end
         end else if (!done && !truncated) begin
            acted = 1'b1;
            case (phase)
               PH_COUNT: begin
                  held_count = data_byte;
                  phase      = PH_VALUE;
               end
               PH_VALUE: begin
                  // run starts over the literal marker already written
                  start              = next_address - 1'b1;
                  want.write_address = start[ADDR_W-1:0];
                  want.write_value   = data_byte;
                  want.run_length    = held_count;
                  next_address       = start + held_count;
                  after_marker       = 1'b0;
                  phase              = PH_NORMAL;
                  update_done();
               end
               default: begin
                  if (compressed && data_byte == MARKER && after_marker) begin
                     phase = PH_COUNT;
                  end else begin
                     want.write_address = next_address[ADDR_W-1:0];
                     want.write_value   = data_byte;
                     want.run_length    = 8'd1;
                     next_address       = next_address + 1'b1;
                     after_marker       = (data_byte == MARKER);
                     update_done();
                  end
               end
            endcase
         end
         want.block_done = done;
         want.truncated  = truncated;
         pending_writes.push_back(want);
         return acted;
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_write(logic [RSP_DATA_W-1:0] data);
         result_type got;
         result_type want;
         got = data[$bits(result_type)-1:0];
         if (pending_writes.size() == 0) begin
            $error("write command 0x%0h arrived with none outstanding", data);
            errors++;
            return;
         end
         want = pending_writes.pop_front();
         compare("write_address", want.write_address, got.write_address);
         compare("write_value", want.write_value, got.write_value);
         compare("run_length", want.run_length, got.run_length);
         compare("block_done", want.block_done, got.block_done);
         compare("truncated", want.truncated, got.truncated);
         compare("padding", 0, data[RSP_DATA_W-1:$bits(result_type)]);
      endfunction

      function int unsigned pending();
         return pending_writes.size();
      endfunction

      function bit stopped();
         return done || truncated;
      endfunction

      function void close();
         if (pending_writes.size() != 0) begin
            $error("%0d write commands never arrived", pending_writes.size());
            errors += pending_writes.size();
         end
      endfunction
   endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for the marker run-length block decoder
// Drives raw stream bytes and end-of-input events into the decoder, changes
// the block settings over the APB port between runs, and checks every write
// command against a tracker that decodes the same stream alongside.
// ----------------------------------------------------------------------------
module tb_top;
   import mrle_pkg::*;
   import mrle_tb_pkg::*;

   localparam int PERIOD_NS    = 20;
   localparam int TIMEOUT_NS   = 4_000_000;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int DECODE_GOAL  = 480;
   localparam int SETTLE_TICKS = 4;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;   // [7:0] data_byte
   logic                  req_tuser   = 1'b0; // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // [15:0] write_address, [23:16] write_value, [31:24] run_length,
   // [32] block_done, [33] truncated, [39:34] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   write_cmd_tracker tracker;
   bit               steady        = 1'b0; // suppress idling on both sides
   int unsigned      decoded_items = 0;

   marker_rle_block_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #(PERIOD_NS / 2) clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: stall about a quarter of the cycles unless in a steady stretch
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99, 0) >= 25);
   end

   // sample each result transfer at the rising edge and check it in order
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_write(rsp_tdata);
      end
   end

   // Drive one stream item. Entered and left at a falling edge; tvalid stays
   // high on return so back-to-back transfers need no lowering in between.
   task automatic send_item(logic kind, logic [7:0] data_byte);
      while (!steady && $urandom_range(99, 0) < 25) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data_byte;
      do @(posedge clock); while (!req_tready);
      if (tracker.note_input(kind, data_byte)) begin
         decoded_items++;
      end
      @(negedge clock);
   endtask

   // marker pair, count and value: one run when compression is on
   task automatic send_marker_run(logic [7:0] count, logic [7:0] value);
      send_item(ITEM_DATA, MARKER);
      send_item(ITEM_DATA, MARKER);
      send_item(ITEM_DATA, count);
      send_item(ITEM_DATA, value);
   endtask

   // Hold the sender off until every outstanding write command has come back,
   // then let the pipeline settle so no restart can overlap a decode step.
   task automatic drain();
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_TICKS) @(posedge clock);
      @(negedge clock);
   endtask

   // APB write: setup phase, access phase, then back to idle
   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_reg(index, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // APB read, compared with the tracker's copy when the access completes
   task automatic csr_check(logic [1:0] index);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.compare("register readback", tracker.read_reg(index), csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write all three settings with junk in the unused upper bits, which the
   // block must drop, then read each back.
   task automatic configure(logic [15:0] base, logic [15:0] length, logic comp);
      csr_write(REG_BASE, {16'($urandom()), base});
      csr_write(REG_LENGTH, {16'($urandom()), length});
      csr_write(REG_COMPRESSED, {31'($urandom()), comp});
      csr_check(REG_BASE);
      csr_check(REG_LENGTH);
      csr_check(REG_COMPRESSED);
   endtask

   // One block with random settings and a mostly well-formed byte stream.
   // Stop once the block is done or truncated or the budget is spent, then push
   // a few stray items through, which are dropped if the block has stopped.
   task automatic random_block(bit pause_midway);
      logic [15:0] base;
      logic [15:0] length;
      logic        comp;
      int unsigned budget;
      int unsigned sent;
      int unsigned roll;
      logic [7:0]  count;
      case ($urandom_range(5, 0))
         0:       base = 16'h0000;
         1:       base = 16'hFFFF;
         2:       base = 16'hFFFF - 16'($urandom_range(255, 0));
         default: base = 16'($urandom());
      endcase
      case ($urandom_range(9, 0))
         0:       length = 16'h0000;
         1:       length = 16'hFFFF;
         2:       length = 16'($urandom_range(8, 1));
         default: length = 16'($urandom_range(400, 16));
      endcase
      // keep the steady stretch long
      if (steady && length < 16'd200) begin
         length = 16'd300;
      end
      comp   = ($urandom_range(3, 0) != 0);
      budget = $urandom_range(80, 30);
      sent   = 0;
      drain();
      configure(base, length, comp);
      while (sent < budget && !tracker.stopped()) begin
         if (pause_midway && sent >= 10) begin
            // hold the sender until the decoder has caught up completely
            drain();
            pause_midway = 1'b0;
         end
         roll = $urandom_range(99, 0);
         if (roll < 3) begin
            send_item(ITEM_END, 8'($urandom()));
            sent++;
         end else if (roll < 35) begin
            count = ($urandom_range(9, 0) < 7) ? 8'($urandom_range(12, 0))
                                               : 8'($urandom());
            send_marker_run(count, 8'($urandom()));
            sent += 4;
         end else if (roll < 45) begin
            // lone marker followed by an ordinary byte
            send_item(ITEM_DATA, MARKER);
            send_item(ITEM_DATA, 8'($urandom()));
            sent += 2;
         end else begin
            send_item(ITEM_DATA, ($urandom_range(9, 0) == 0) ? MARKER : 8'($urandom()));
            sent++;
         end
      end
      repeat ($urandom_range(3, 1)) begin
         send_item(1'($urandom()), 8'($urandom()));
      end
   endtask

   initial begin
      int unsigned blocks;
      tracker = new();
      blocks  = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: base 0x4000, length 0xC000 (to the top of the address space), compression on
      csr_check(REG_BASE);
      csr_check(REG_LENGTH);
      csr_check(REG_COMPRESSED);
      send_item(ITEM_DATA, 8'h00);
      send_marker_run(8'd5, 8'hAA);     // run laid over the literal marker
      send_marker_run(8'd0, 8'h11);     // zero count steps the address back
      send_item(ITEM_DATA, MARKER);     // marker then ordinary byte: literals
      send_item(ITEM_DATA, 8'h12);

      // long run near the top of the address space overshoots the block end,
      // then data and end of input after done are both dropped
      drain();
      configure(16'hFFF0, 16'h0020, 1'b1);
      send_marker_run(8'hFF, 8'h55);
      send_item(ITEM_DATA, 8'h01);
      send_item(ITEM_END, 8'hFF);

      // literal copy across the 64K wrap of the reported address
      drain();
      configure(16'hFFFF, 16'hFFFF, 1'b0);
      send_item(ITEM_DATA, 8'h3C);
      send_item(ITEM_DATA, 8'hC3);

      // empty block: done at once, nothing written
      drain();
      csr_write(REG_LENGTH, 32'h0000_0000);
      send_item(ITEM_DATA, 8'h77);
      send_item(ITEM_END, 8'h00);

      // end of input before done: truncated sticks, later bytes dropped; an
      // unmapped register write must not restart the block
      drain();
      configure(16'h0000, 16'h0008, 1'b0);
      send_item(ITEM_DATA, MARKER);
      send_item(ITEM_DATA, MARKER);
      send_item(ITEM_DATA, MARKER);
      send_item(ITEM_DATA, 8'h7F);
      send_item(ITEM_END, 8'h00);
      send_item(ITEM_DATA, 8'h20);
      drain();
      csr_write(REG_UNUSED, $urandom());
      send_item(ITEM_DATA, 8'h21);

      // random blocks until enough bytes have actually been decoded
      while (decoded_items < DECODE_GOAL) begin
         steady = (blocks == 3);
         random_block(blocks == 1);
         blocks++;
      end
      steady = 1'b0;

      drain();
      tracker.close();
      if (tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
